@@ rtl/box_blur_5x5_rgb_macros.svh @@
// Assertion helpers for the box blur block.
`ifndef BOX_BLUR_5X5_RGB_MACROS_SVH
`define BOX_BLUR_5X5_RGB_MACROS_SVH

// Check that a condition implies another at the same edge.
`define BB_ASSERT_IMPL(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bb: %s", "label");

// Check that a condition implies another at the next edge.
`define BB_ASSERT_NEXT(label, clk, rst_n, a, b) \
label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bb: %s", "label");

`endif

@@ rtl/bb_pkg.sv @@
// ----------------------------------------------------------------------------
// bb_pkg
// Shared types and constants of the 5x5 box blur.
// ----------------------------------------------------------------------------
package bb_pkg;
    localparam int MaxWidth = 2048;
    localparam int Radius   = 2;
    localparam int Slots    = 2 * Radius + 2;
    localparam int Taps     = 2 * Radius + 1;
    localparam int ColW     = 11;
    localparam int RowW     = 13;
    localparam int SlotW    = 3;
    localparam int AddrW    = 14;
    localparam int Depth    = 16384;
    localparam int PixW     = 24;
    localparam int SumW     = 13;
    localparam int CntW     = 5;

    localparam logic [0:0] OP_PIXEL = 1'b0;
    localparam logic [0:0] OP_FLUSH = 1'b1;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    // input channel payload
    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] chan0;
        logic [7:0] chan1;
        logic [7:0] chan2;
    } pixel_item_t;

    // output channel payload
    typedef struct packed {
        logic [7:0] chan0_mean;
        logic [7:0] chan1_mean;
        logic [7:0] chan2_mean;
        logic       last_pixel;
    } mean_item_t;

    // controller to datapath
    typedef struct packed {
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        logic [PixW-1:0]  wr_data;
        logic             rd_en;
        logic [AddrW-1:0] rd_addr;
        logic             rd_ok;
        logic             acc_clr;
        logic             acc_en;
        logic             div_start;
        logic [CntW-1:0]  count;
    } bb_cmd_t;

    typedef struct packed {
        logic            div_busy;
        logic            div_done;
    } bb_stat_t;
endpackage

@@ rtl/bb_if.sv @@
// ----------------------------------------------------------------------------
// bb_if
// Valid/ready stream channel carrying a payload struct.
// ----------------------------------------------------------------------------
interface bb_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bb_ram.sv @@
// ----------------------------------------------------------------------------
// bb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/bb_datapath.sv @@
// ----------------------------------------------------------------------------
// bb_datapath
// Line store, per-channel window accumulators and a shared restoring divider.
// ----------------------------------------------------------------------------
`include "box_blur_5x5_rgb_macros.svh"
module bb_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bb_pkg::bb_cmd_t   cmd,
    output bb_pkg::bb_stat_t  stat,
    output logic [7:0]        q0,
    output logic [7:0]        q1,
    output logic [7:0]        q2
);
    localparam int SW = bb_pkg::SumW;

    logic [bb_pkg::PixW-1:0] rd_data;
    logic                    ok_reg;
    logic                    acc_reg;
    logic [SW-1:0]           s0_reg, s1_reg, s2_reg;
    logic [SW-1:0]           r0_reg, r1_reg, r2_reg;
    logic [SW-1:0]           d0_reg, d1_reg, d2_reg;
    logic [bb_pkg::CntW-1:0] n_reg;
    logic [3:0]              step_reg;
    logic                    busy_reg, done_reg;
    logic [SW:0]             t0, t1, t2;

    bb_ram #(.WIDTH(bb_pkg::PixW), .DEPTH(bb_pkg::Depth)) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (cmd.wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    // restoring division, one quotient bit per cycle, MSB first
    assign t0 = {r0_reg[SW-2:0], d0_reg[SW-1], 1'b0} >> 1;
    assign t1 = {r1_reg[SW-2:0], d1_reg[SW-1], 1'b0} >> 1;
    assign t2 = {r2_reg[SW-2:0], d2_reg[SW-1], 1'b0} >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg   <= 1'b0;
            acc_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            ok_reg   <= cmd.rd_ok;
            acc_reg  <= cmd.acc_en;
            done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'(SW - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (acc_reg && ok_reg)
        begin
            s0_reg <= s0_reg + SW'(rd_data[7:0]);
            s1_reg <= s1_reg + SW'(rd_data[15:8]);
            s2_reg <= s2_reg + SW'(rd_data[23:16]);
        end
        if (cmd.div_start)
        begin
            d0_reg <= s0_reg;
            d1_reg <= s1_reg;
            d2_reg <= s2_reg;
            r0_reg <= '0;
            r1_reg <= '0;
            r2_reg <= '0;
            n_reg  <= cmd.count;
        end
        else if (busy_reg)
        begin
            if (t0[SW-1:0] >= SW'(n_reg))
            begin
                r0_reg <= t0[SW-1:0] - SW'(n_reg);
                d0_reg <= {d0_reg[SW-2:0], 1'b1};
            end
            else
            begin
                r0_reg <= t0[SW-1:0];
                d0_reg <= {d0_reg[SW-2:0], 1'b0};
            end
            if (t1[SW-1:0] >= SW'(n_reg))
            begin
                r1_reg <= t1[SW-1:0] - SW'(n_reg);
                d1_reg <= {d1_reg[SW-2:0], 1'b1};
            end
            else
            begin
                r1_reg <= t1[SW-1:0];
                d1_reg <= {d1_reg[SW-2:0], 1'b0};
            end
            if (t2[SW-1:0] >= SW'(n_reg))
            begin
                r2_reg <= t2[SW-1:0] - SW'(n_reg);
                d2_reg <= {d2_reg[SW-2:0], 1'b1};
            end
            else
            begin
                r2_reg <= t2[SW-1:0];
                d2_reg <= {d2_reg[SW-2:0], 1'b0};
            end
        end
    end

    assign stat.div_busy = busy_reg;
    assign stat.div_done = done_reg;
    assign q0 = d0_reg[7:0];
    assign q1 = d1_reg[7:0];
    assign q2 = d2_reg[7:0];

    `BB_ASSERT_NEXT(a_start_busy, clk, rst_n, cmd.div_start, busy_reg)
    `BB_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, !busy_reg)
    `BB_ASSERT_IMPL(a_no_zero_div, clk, rst_n, cmd.div_start, cmd.count != '0)
endmodule

@@ rtl/bb_ctrl.sv @@
// ----------------------------------------------------------------------------
// bb_ctrl
// Sequencer: counts positions, writes the line store, walks the window.
// ----------------------------------------------------------------------------
`include "box_blur_5x5_rgb_macros.svh"
module bb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_idx,
    input  logic [11:0]      cfg_width,
    input  logic [12:0]      cfg_height,
    input  logic             in_valid,
    input  logic [0:0]       in_op,
    input  logic [23:0]      in_pix,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_last,
    output bb_pkg::bb_cmd_t  cmd,
    input  bb_pkg::bb_stat_t stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_START, S_DIV, S_OUT
    } state_t;

    localparam int RW = bb_pkg::RowW;
    localparam int CW = bb_pkg::ColW;
    localparam int SW = bb_pkg::SlotW;

    state_t          state_reg;
    logic [CW:0]     w_reg;     // effective width, 1..MaxWidth
    logic [RW-1:0]   h_reg;     // effective height
    logic [RW-1:0]   in_row_reg, out_row_reg;
    logic [CW-1:0]   in_col_reg, out_col_reg;
    logic [SW-1:0]   in_slot_reg, out_slot_reg;
    logic            all_in_reg;
    logic [2:0]      dr_reg, dc_reg;
    logic [bb_pkg::CntW-1:0] n_reg;
    logic            last_reg;
    logic            valid_reg;
    logic [26:0]     got, nxt;
    logic [RW:0]     rr;
    logic [CW+1:0]   cc;
    logic            tap_ok;
    logic [SW:0]     slot_sum;
    logic [SW-1:0]   slot;
    logic [RW-1:0]   in_row_n;
    logic [CW-1:0]   in_col_n;
    logic [SW-1:0]   in_slot_n;
    logic            all_in_n;
    logic [CW:0]     w_eff;

    always_comb
    begin
        w_eff = (cfg_width == '0) ? (CW+1)'(1) :
                (cfg_width > 12'(bb_pkg::MaxWidth)) ? (CW+1)'(bb_pkg::MaxWidth) :
                cfg_width[CW:0];
    end

    // next input position after a stored pixel
    always_comb
    begin
        in_row_n  = in_row_reg;
        in_col_n  = in_col_reg + CW'(1);
        in_slot_n = in_slot_reg;
        all_in_n  = all_in_reg;
        if ((CW+1)'(in_col_reg) + (CW+1)'(1) >= w_reg)
        begin
            in_col_n  = '0;
            in_row_n  = in_row_reg + RW'(1);
            in_slot_n = (in_slot_reg == SW'(bb_pkg::Slots - 1)) ? '0 : in_slot_reg + SW'(1);
            if (in_row_reg + RW'(1) >= h_reg)
            begin
                all_in_n = 1'b1;
            end
        end
        got = 27'(in_row_n) * 27'(w_reg) + 27'(in_col_n);
        nxt = 27'(out_row_reg) * 27'(w_reg) + 27'(out_col_reg)
            + 27'(w_reg) * 27'(bb_pkg::Radius) + 27'(bb_pkg::Radius);
    end

    // current window tap
    always_comb
    begin
        rr = (RW+1)'(out_row_reg) + (RW+1)'(dr_reg) - (RW+1)'(bb_pkg::Radius);
        cc = (CW+2)'(out_col_reg) + (CW+2)'(dc_reg) - (CW+2)'(bb_pkg::Radius);
        tap_ok = !rr[RW] && (rr[RW-1:0] < h_reg) && !cc[CW+1] && (cc[CW:0] < w_reg);
        // ring slot of the tap row: out_slot + dr - Radius, wrapped into the ring
        slot_sum = (SW+1)'(out_slot_reg) + (SW+1)'(dr_reg)
                 + (SW+1)'(bb_pkg::Slots - bb_pkg::Radius);
        if (slot_sum >= (SW+1)'(2 * bb_pkg::Slots))
        begin
            slot = SW'(slot_sum - (SW+1)'(2 * bb_pkg::Slots));
        end
        else if (slot_sum >= (SW+1)'(bb_pkg::Slots))
        begin
            slot = SW'(slot_sum - (SW+1)'(bb_pkg::Slots));
        end
        else
        begin
            slot = SW'(slot_sum);
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !cfg_we;
    assign out_valid = valid_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.wr_en     = in_valid && in_ready && (in_op == bb_pkg::OP_PIXEL) && !all_in_reg;
        cmd.wr_addr   = {in_slot_reg, in_col_reg};
        cmd.wr_data   = in_pix;
        cmd.rd_en     = (state_reg == S_WALK);
        cmd.rd_addr   = {slot, cc[CW-1:0]};
        cmd.rd_ok     = (state_reg == S_WALK) && tap_ok;
        cmd.acc_en    = (state_reg == S_WALK);
        cmd.acc_clr   = (state_reg == S_IDLE);
        cmd.div_start = (state_reg == S_START);
        cmd.count     = n_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            w_reg        <= (CW+1)'(640);
            h_reg        <= RW'(480);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            all_in_reg   <= 1'b0;
            dr_reg       <= '0;
            dc_reg       <= '0;
            n_reg        <= '0;
            last_reg     <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        if (cfg_idx == bb_pkg::REG_WIDTH)
                        begin
                            w_reg <= w_eff;
                        end
                        else
                        begin
                            h_reg <= (cfg_height == '0) ? RW'(1) : cfg_height;
                        end
                        in_row_reg   <= '0;
                        in_col_reg   <= '0;
                        in_slot_reg  <= '0;
                        out_row_reg  <= '0;
                        out_col_reg  <= '0;
                        out_slot_reg <= '0;
                        all_in_reg   <= 1'b0;
                    end
                    else if (in_valid)
                    begin
                        dr_reg <= '0;
                        dc_reg <= '0;
                        n_reg  <= '0;
                        if (cmd.wr_en)
                        begin
                            in_row_reg  <= in_row_n;
                            in_col_reg  <= in_col_n;
                            in_slot_reg <= in_slot_n;
                            all_in_reg  <= all_in_n;
                            if (all_in_n || (got > nxt))
                            begin
                                state_reg <= S_WALK;
                            end
                        end
                        else if (all_in_reg)
                        begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (tap_ok)
                    begin
                        n_reg <= n_reg + bb_pkg::CntW'(1);
                    end
                    if (dc_reg == 3'(bb_pkg::Taps - 1))
                    begin
                        dc_reg <= '0;
                        if (dr_reg == 3'(bb_pkg::Taps - 1))
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            dr_reg <= dr_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        dc_reg <= dc_reg + 3'd1;
                    end
                end
                S_DRAIN:
                begin
                    // last read lands in the accumulators at the end of this cycle
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (stat.div_done)
                    begin
                        valid_reg <= 1'b1;
                        last_reg  <= (out_row_reg == h_reg - RW'(1))
                                  && ((CW+1)'(out_col_reg) == w_reg - (CW+1)'(1));
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                        if ((CW+1)'(out_col_reg) + (CW+1)'(1) >= w_reg)
                        begin
                            out_col_reg <= '0;
                            if (out_row_reg + RW'(1) >= h_reg)
                            begin
                                in_row_reg   <= '0;
                                in_col_reg   <= '0;
                                in_slot_reg  <= '0;
                                out_row_reg  <= '0;
                                out_slot_reg <= '0;
                                all_in_reg   <= 1'b0;
                            end
                            else
                            begin
                                out_row_reg  <= out_row_reg + RW'(1);
                                out_slot_reg <= (out_slot_reg == SW'(bb_pkg::Slots - 1)) ?
                                                '0 : out_slot_reg + SW'(1);
                            end
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `BB_ASSERT_IMPL(a_valid_out, clk, rst_n, valid_reg, state_reg == S_OUT)
    `BB_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !valid_reg)
    `BB_ASSERT_IMPL(a_cnt_max, clk, rst_n, state_reg == S_DIV, n_reg != '0)
endmodule

@@ rtl/box_blur_5x5_rgb.sv @@
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb
// Streaming 5x5 mean filter over three 8-bit channels with border handling.
// ----------------------------------------------------------------------------
// An input item that yields no output does not hold off the next item. An item
// that yields an output holds the input off until its result is taken: 25
// line-store reads through the single read port of the RAM, the last read
// landing in the accumulators, the load of the shared bit-serial divider,
// 13 divide steps and its done flag, then the transfer of the result; any
// stall on the output adds to this. Outputs trail the input by two rows and
// two columns; flush items drain the rest. The line store holds six rows of
// up to 2048 pixels and needs no clearing.
module box_blur_5x5_rgb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data,
    bb_if.sink          in_ch,
    bb_if.source        out_ch
);
    bb_pkg::bb_cmd_t  cmd;
    bb_pkg::bb_stat_t stat;
    logic [7:0]       q0, q1, q2;
    logic             last;

    bb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_index),
        .cfg_width  (cfg_data[11:0]),
        .cfg_height (cfg_data),
        .in_valid   (in_ch.valid),
        .in_op      (in_ch.data.opcode),
        .in_pix     ({in_ch.data.chan2, in_ch.data.chan1, in_ch.data.chan0}),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_last   (last),
        .cmd        (cmd),
        .stat       (stat)
    );

    bb_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .q0    (q0),
        .q1    (q1),
        .q2    (q2)
    );

    assign out_ch.data.chan0_mean = q0;
    assign out_ch.data.chan1_mean = q1;
    assign out_ch.data.chan2_mean = q2;
    assign out_ch.data.last_pixel = last;
endmodule
